// File: sv/hvt_pkg.sv
// Types and constants for the homogeneous vector transform.
package hvt_pkg;

  localparam int NUM_REGS  = 8;
  localparam int REG_W     = 64;
  localparam int REG_IDX_W = 3;
  localparam int FIELD_W   = 32;

  typedef enum logic [1:0] {
    OP_POINT_COL = 2'd0,
    OP_POINT_ROW = 2'd1,
    OP_DIR_COL   = 2'd2,
    OP_DIR_ROW   = 2'd3
  } op_t;

  localparam logic [REG_W-1:0] CFG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

  typedef struct packed {
    op_t                       operation;
    logic signed [FIELD_W-1:0] vec_x;
    logic signed [FIELD_W-1:0] vec_y;
    logic signed [FIELD_W-1:0] vec_z;
  } vec_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_z;
    logic                      divide_by_zero;
    logic                      saturated;
  } res_t;

endpackage

// File: sv/homogeneous_vector_transform.sv
// Pipelined 4x4 homogeneous vector transform with per-bit divide stages.
//
//  channel   valid      stall      payload
//  request   vec_valid  vec_stall  vec (hvt_pkg::vec_t)
//  result    res_valid  res_stall  res (hvt_pkg::res_t)
//  config    cfg_write  -          cfg_index, cfg_data
//
// One request per cycle while the result is not stalled.
// Pipeline depth is set by the restoring divider: one quotient bit per stage.
// All stages advance together whenever the result register is empty or taken.
// A stalled result holds the whole pipe and raises vec_stall.
// Reset clears the valid bits and loads the identity matrix.
module homogeneous_vector_transform #(
  parameter int FRAC_BITS  = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [hvt_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [hvt_pkg::REG_W-1:0]     cfg_data,
  input  logic                          vec_valid,
  output logic                          vec_stall,
  input  hvt_pkg::vec_t                 vec,
  output logic                          res_valid,
  input  logic                          res_stall,
  output hvt_pkg::res_t                 res
);

  localparam int W     = WORD_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int PW    = 2 * W;
  localparam int ACC_W = 2 * W + 2;
  localparam int NQ    = W + 1;
  localparam int DW    = ACC_W + F + W + 1;
  localparam int NS    = NQ + 6;
  localparam int OW    = hvt_pkg::FIELD_W;
  localparam logic [W:0] HALF = (W + 1)'(1) << (W - 1);
  localparam logic [W-1:0] WMAX = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W - 1){1'b0}}};

  logic [hvt_pkg::REG_W-1:0] cfg_reg [hvt_pkg::NUM_REGS];
  logic [NS-1:0] vld;
  logic          adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < hvt_pkg::NUM_REGS; r++) cfg_reg[r] <= hvt_pkg::CFG_RESET[r];
    end else if (cfg_write) begin
      cfg_reg[cfg_index] <= cfg_data;
    end
  end

  assign adv       = !vld[NS-1] || !res_stall;
  assign vec_stall = !adv;
  assign res_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], vec_valid};
    end
  end

  // stage 0: capture vector and select matrix orientation
  logic row_in, dir_in;
  logic signed [W-1:0] sel [4][4];
  logic signed [W-1:0] a0 [4][4];
  logic signed [W-1:0] v0 [3];
  logic dir0;

  assign row_in = (vec.operation == hvt_pkg::OP_POINT_ROW) ||
                  (vec.operation == hvt_pkg::OP_DIR_ROW);
  assign dir_in = (vec.operation == hvt_pkg::OP_DIR_COL) ||
                  (vec.operation == hvt_pkg::OP_DIR_ROW);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        sel[i][j] = row_in ? cfg_reg[j * 2 + i / 2][(i % 2) * 32 +: W]
                           : cfg_reg[i * 2 + j / 2][(j % 2) * 32 +: W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a0   <= sel;
      v0[0] <= vec.vec_x[W-1:0];
      v0[1] <= vec.vec_y[W-1:0];
      v0[2] <= vec.vec_z[W-1:0];
      dir0 <= dir_in;
    end
  end

  // stage 1: products
  logic signed [PW-1:0] p1 [4][4];
  logic dir1;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 3; j++) p1[i][j] <= PW'(a0[i][j]) * PW'(v0[j]);
        p1[i][3] <= dir0 ? '0 : (PW'(a0[i][3]) <<< F);
      end
      dir1 <= dir0;
    end
  end

  // stage 2: sums
  logic signed [ACC_W-1:0] acc2 [4];
  logic dir2;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        acc2[i] <= ACC_W'(p1[i][0]) + ACC_W'(p1[i][1]) + ACC_W'(p1[i][2]) + ACC_W'(p1[i][3]);
      end
      dir2 <= dir1;
    end
  end

  // stage 3: direction result, magnitudes for point divide
  logic signed [ACC_W-1:0] sh2 [3];
  logic [W-1:0]     dres_n [3];
  logic             dsat_n;
  logic [W-1:0]     dres3 [3];
  logic             dsat3, dir3, dz3;
  logic [ACC_W-1:0] nmag3 [3];
  logic [ACC_W-1:0] dmag3;
  logic             neg3 [3];

  always_comb begin
    dsat_n = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sh2[i] = acc2[i] >>> F;
      if ((&sh2[i][ACC_W-1:W-1]) || !(|sh2[i][ACC_W-1:W-1])) begin
        dres_n[i] = sh2[i][W-1:0];
      end else begin
        dres_n[i] = sh2[i][ACC_W-1] ? WMIN : WMAX;
        dsat_n    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dir3  <= dir2;
      dres3 <= dres_n;
      dsat3 <= dsat_n;
      dz3   <= (acc2[3] == '0);
      dmag3 <= acc2[3][ACC_W-1] ? $unsigned(-acc2[3]) : $unsigned(acc2[3]);
      for (int i = 0; i < 3; i++) begin
        nmag3[i] <= acc2[i][ACC_W-1] ? $unsigned(-acc2[i]) : $unsigned(acc2[i]);
        neg3[i]  <= acc2[i][ACC_W-1] ^ acc2[3][ACC_W-1];
      end
    end
  end

  // divide stages: index 0 is setup, then one quotient bit per stage
  logic [DW-1:0]    rem  [NQ+1][3];
  logic [W:0]       quo  [NQ+1][3];
  logic             ovf  [NQ+1][3];
  logic             neg  [NQ+1][3];
  logic [ACC_W-1:0] dmag [NQ+1];
  logic [W-1:0]     dres [NQ+1][3];
  logic             dsat [NQ+1];
  logic             dirk [NQ+1];
  logic             dzk  [NQ+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        rem[0][i] <= DW'(nmag3[i]) << F;
        quo[0][i] <= '0;
        ovf[0][i] <= (DW'(nmag3[i]) << F) >= (DW'(dmag3) << (W + 1));
        neg[0][i] <= neg3[i];
      end
      dmag[0] <= dmag3;
      dres[0] <= dres3;
      dsat[0] <= dsat3;
      dirk[0] <= dir3;
      dzk[0]  <= dz3;
    end
  end

  for (genvar t = 1; t <= NQ; t++) begin : g_div
    localparam int K = NQ - t;
    logic [DW-1:0] dk;
    assign dk = DW'(dmag[t-1]) << K;

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          if (rem[t-1][i] >= dk) begin
            rem[t][i] <= rem[t-1][i] - dk;
            quo[t][i] <= quo[t-1][i] | ((W + 1)'(1) << K);
          end else begin
            rem[t][i] <= rem[t-1][i];
            quo[t][i] <= quo[t-1][i];
          end
          ovf[t][i] <= ovf[t-1][i];
          neg[t][i] <= neg[t-1][i];
        end
        dmag[t] <= dmag[t-1];
        dres[t] <= dres[t-1];
        dsat[t] <= dsat[t-1];
        dirk[t] <= dirk[t-1];
        dzk[t]  <= dzk[t-1];
      end
    end
  end

  // final stage: sign, clip, result register
  logic [W-1:0] pres [3];
  logic         psat;
  logic [W:0]   qneg [3];
  hvt_pkg::res_t res_next;

  always_comb begin
    psat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      qneg[i] = -quo[NQ][i];
      if (neg[NQ][i]) begin
        if (ovf[NQ][i] || quo[NQ][i] > HALF) begin
          pres[i] = WMIN;
          psat    = 1'b1;
        end else begin
          pres[i] = qneg[i][W-1:0];
        end
      end else begin
        if (ovf[NQ][i] || quo[NQ][i] >= HALF) begin
          pres[i] = WMAX;
          psat    = 1'b1;
        end else begin
          pres[i] = quo[NQ][i][W-1:0];
        end
      end
    end
    if (dirk[NQ]) begin
      res_next.out_x          = OW'($signed(dres[NQ][0]));
      res_next.out_y          = OW'($signed(dres[NQ][1]));
      res_next.out_z          = OW'($signed(dres[NQ][2]));
      res_next.divide_by_zero = 1'b0;
      res_next.saturated      = dsat[NQ];
    end else if (dzk[NQ]) begin
      res_next.out_x          = '0;
      res_next.out_y          = '0;
      res_next.out_z          = '0;
      res_next.divide_by_zero = 1'b1;
      res_next.saturated      = 1'b0;
    end else begin
      res_next.out_x          = OW'($signed(pres[0]));
      res_next.out_y          = OW'($signed(pres[1]));
      res_next.out_z          = OW'($signed(pres[2]));
      res_next.divide_by_zero = 1'b0;
      res_next.saturated      = psat;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

endmodule

// File: sv/hvt_checker.sv
// Port-level checks for the homogeneous vector transform, bound to the top level.
module hvt_checker (
  input logic          clk,
  input logic          rst,
  input logic          vec_valid,
  input logic          vec_stall,
  input logic          res_valid,
  input logic          res_stall,
  input hvt_pkg::res_t res
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !vec_stall)
    else $error("request stalled with empty result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (vec_valid && vec_stall) |-> (res_valid && res_stall))
    else $error("request stalled without a waiting result");

  a_dz_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.divide_by_zero) |->
      (!res.saturated && res.out_x == '0 && res.out_y == '0 && res.out_z == '0))
    else $error("divide-by-zero result not clean");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res)))
    else $error("stalled result changed");

endmodule

bind homogeneous_vector_transform hvt_checker u_hvt_checker (
  .clk       (clk),
  .rst       (rst),
  .vec_valid (vec_valid),
  .vec_stall (vec_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
